// ===== sv/wsfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 64;
   localparam int KEY_W    = 32;
   localparam int OPCODE_W = 4;

   // 7-bit length codes that announce an extended length field
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   localparam logic ITEM_HEADER  = 1'b0;
   localparam logic ITEM_PAYLOAD = 1'b1;

   typedef enum logic [2:0] {
      PH_BYTE1   = 3'd0,
      PH_BYTE2   = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef struct packed {
      logic                  item_kind;
      logic                  fin_flag;
      logic [OPCODE_W-1:0]   frame_opcode;
      logic                  mask_flag;
      logic [LEN_W-1:0]      frame_length;
      logic [BYTE_W-1:0]     payload_byte;
      logic                  frame_end;
   } result_type;

endpackage
`default_nettype wire

// ===== sv/websocket_frame_deframer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Splits a received byte stream into WebSocket frames (RFC 6455 framing).
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: one received stream byte per transfer on req_rx_byte.
//  - Response channel: one result per transfer. A header result (item_kind 0)
//    follows the last header byte; a payload result (item_kind 1) follows
//    every payload byte, unmasked with key byte (index mod 4).
//  - frame_end marks the last result of a frame: the header result of an
//    empty frame, otherwise the last payload byte.
//  - Header bytes that complete nothing give no result.
//  - A result is registered and appears in the cycle after the byte that causes it.
//  - Throughput: one byte per cycle, set by the single result register, while
//    no result is blocked; the parser state updates in the same cycle a byte is taken.
//  - The receiver may stall: a waiting result holds, and req_stall rises
//    only while the result register is full and rsp_stall is high.
//  - Reset (synchronous, active high) returns the parser to the first
//    header byte and empties the result register; no sweep is needed.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [wsfd_pkg::BYTE_W-1:0]          req_rx_byte,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_item_kind,
   output logic                                      rsp_fin_flag,
   output logic [wsfd_pkg::OPCODE_W-1:0]             rsp_frame_opcode,
   output logic                                      rsp_mask_flag,
   output logic [wsfd_pkg::LEN_W-1:0]                rsp_frame_length,
   output logic [wsfd_pkg::BYTE_W-1:0]               rsp_payload_byte,
   output logic                                      rsp_frame_end
);

   logic                  byte_take;   // request transfer this cycle
   logic                  res_valid;   // accepted byte yields a result
   logic                  out_busy;
   wsfd_pkg::result_type  res;
   wsfd_pkg::result_type  rsp_data;

   // The input side stalls only while a result waits and cannot drain.
   assign req_stall = out_busy;
   assign byte_take = req_valid & ~out_busy;

   wsfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (byte_take & res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .busy      (out_busy)
   );

   // unpack the result register onto the response ports
   assign rsp_item_kind    = rsp_data.item_kind;
   assign rsp_fin_flag     = rsp_data.fin_flag;
   assign rsp_frame_opcode = rsp_data.frame_opcode;
   assign rsp_mask_flag    = rsp_data.mask_flag;
   assign rsp_frame_length = rsp_data.frame_length;
   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_frame_end    = rsp_data.frame_end;

endmodule
`default_nettype wire

// ===== sv/wsfd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame header parser and payload unmasking, one byte per accepted transfer.
// ----------------------------------------------------------------------------
module wsfd_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        byte_take,
   input  wire logic [wsfd_pkg::BYTE_W-1:0] rx_byte,
   output logic                             res_valid,
   output wsfd_pkg::result_type             res
);

   wsfd_pkg::phase_type           phase_ff,     phase_in;
   logic [wsfd_pkg::BYTE_W-1:0]   hdr1_ff,      hdr1_in;
   logic                          masked_ff,    masked_in;
   logic [3:0]                    len_left_ff,  len_left_in;
   logic [wsfd_pkg::LEN_W-1:0]    len_acc_ff,   len_acc_in;
   logic [wsfd_pkg::KEY_W-1:0]    key_ff,       key_in;
   logic [2:0]                    key_left_ff,  key_left_in;
   logic [wsfd_pkg::LEN_W-1:0]    pay_left_ff,  pay_left_in;
   logic [1:0]                    key_idx_ff,   key_idx_in;

   logic                          len_done;
   logic                          hdr_done;
   logic                          last;
   logic [3:0]                    len_dec;
   logic [2:0]                    key_dec;
   logic [wsfd_pkg::LEN_W-1:0]    pay_dec;
   logic [wsfd_pkg::BYTE_W-1:0]   key_byte;

   always_comb begin
      phase_in    = phase_ff;
      hdr1_in     = hdr1_ff;
      masked_in   = masked_ff;
      len_left_in = len_left_ff;
      len_acc_in  = len_acc_ff;
      key_in      = key_ff;
      key_left_in = key_left_ff;
      pay_left_in = pay_left_ff;
      key_idx_in  = key_idx_ff;
      len_done    = 1'b0;
      hdr_done    = 1'b0;
      last        = 1'b0;
      res_valid   = 1'b0;

      // saturating down-counts
      len_dec  = (len_left_ff != 4'd0) ? len_left_ff - 4'd1 : 4'd0;
      key_dec  = (key_left_ff != 3'd0) ? key_left_ff - 3'd1 : 3'd0;
      pay_dec  = (pay_left_ff != '0) ? pay_left_ff - 64'd1 : '0;

      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase

      res.item_kind    = wsfd_pkg::ITEM_PAYLOAD;
      res.fin_flag     = hdr1_ff[7];
      res.frame_opcode = hdr1_ff[3:0];
      res.mask_flag    = masked_ff;
      res.frame_length = len_acc_ff;
      res.payload_byte = rx_byte ^ key_byte;
      res.frame_end    = 1'b0;

      case (phase_ff)
         wsfd_pkg::PH_BYTE2: begin
            masked_in  = rx_byte[7];
            len_acc_in = '0;
            if (rx_byte[6:0] == wsfd_pkg::LEN7_EXT16) begin
               len_left_in = wsfd_pkg::EXT16_BYTES;
               phase_in    = wsfd_pkg::PH_EXTLEN;
            end else if (rx_byte[6:0] == wsfd_pkg::LEN7_EXT64) begin
               len_left_in = wsfd_pkg::EXT64_BYTES;
               phase_in    = wsfd_pkg::PH_EXTLEN;
            end else begin
               len_acc_in = {57'd0, rx_byte[6:0]};
               len_done   = 1'b1;
            end
         end
         wsfd_pkg::PH_EXTLEN: begin
            len_acc_in  = {len_acc_ff[wsfd_pkg::LEN_W-9:0], rx_byte};
            len_left_in = len_dec;
            len_done    = (len_dec == 4'd0);
         end
         wsfd_pkg::PH_KEY: begin
            key_in      = {key_ff[wsfd_pkg::KEY_W-9:0], rx_byte};
            key_left_in = key_dec;
            hdr_done    = (key_dec == 3'd0);
         end
         wsfd_pkg::PH_PAYLOAD: begin
            key_idx_in  = key_idx_ff + 2'd1;
            pay_left_in = pay_dec;
            last        = (pay_dec == '0);
            if (last) begin
               phase_in = wsfd_pkg::PH_BYTE1;
            end
            res_valid     = 1'b1;
            res.frame_end = last;
         end
         default: begin
            hdr1_in  = rx_byte;
            phase_in = wsfd_pkg::PH_BYTE2;
         end
      endcase

      // length complete: fetch the key, or finish the header straight away
      if (len_done) begin
         key_in = '0;
         if (masked_in) begin
            key_left_in = wsfd_pkg::KEY_BYTES;
            phase_in    = wsfd_pkg::PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         last        = (len_acc_in == '0);
         pay_left_in = len_acc_in;
         key_idx_in  = 2'd0;
         phase_in    = last ? wsfd_pkg::PH_BYTE1 : wsfd_pkg::PH_PAYLOAD;
         res_valid        = 1'b1;
         res.item_kind    = wsfd_pkg::ITEM_HEADER;
         res.mask_flag    = masked_in;
         res.frame_length = len_acc_in;
         res.payload_byte = '0;
         res.frame_end    = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wsfd_pkg::PH_BYTE1;
         hdr1_ff     <= '0;
         masked_ff   <= 1'b0;
         len_left_ff <= '0;
         len_acc_ff  <= '0;
         key_ff      <= '0;
         key_left_ff <= '0;
         pay_left_ff <= '0;
         key_idx_ff  <= '0;
      end else if (byte_take) begin
         phase_ff    <= phase_in;
         hdr1_ff     <= hdr1_in;
         masked_ff   <= masked_in;
         len_left_ff <= len_left_in;
         len_acc_ff  <= len_acc_in;
         key_ff      <= key_in;
         key_left_ff <= key_left_in;
         pay_left_ff <= pay_left_in;
         key_idx_ff  <= key_idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/wsfd_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_out_reg
// Result register with valid/stall handshake towards the receiver.
// ----------------------------------------------------------------------------
module wsfd_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire wsfd_pkg::result_type  res,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output wsfd_pkg::result_type       rsp_data,
   output logic                       busy
);

   logic                  valid_ff, valid_in;
   wsfd_pkg::result_type  data_ff;

   // full and not draining this cycle
   assign busy     = valid_ff & rsp_stall;
   assign valid_in = load | busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

// ===== sv/wsfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks of the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsfd_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_stall,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic                              rsp_item_kind,
   input  wire logic [wsfd_pkg::LEN_W-1:0]        rsp_frame_length,
   input  wire logic [wsfd_pkg::BYTE_W-1:0]       rsp_payload_byte,
   input  wire logic                              rsp_frame_end
);

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_frame_length) && $stable(rsp_item_kind))
      else $error("response changed while stalled");

   // header result ends the frame exactly when the length is zero
   a_hdr_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == wsfd_pkg::ITEM_HEADER
         |-> rsp_frame_end == (rsp_frame_length == '0))
      else $error("header frame_end does not match length");

   a_hdr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == wsfd_pkg::ITEM_HEADER |-> rsp_payload_byte == '0)
      else $error("header result carries a payload byte");

   // input back-pressure only comes from a blocked result
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   // first edge out of reset: result register empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind websocket_frame_deframer_top wsfd_checker u_wsfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_item_kind    (rsp_item_kind),
   .rsp_frame_length (rsp_frame_length),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_frame_end    (rsp_frame_end)
);
`default_nettype wire

// ===== tb/websocket_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top_tb
// Feeds a WebSocket byte stream (directed frames, then random frames with a
// few truncated ones) into the deframer with random idling on both sides and
// checks every response transfer against an in-bench frame parser.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top_tb;

   // length encodings a generated frame header may use
   typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_type;

   localparam int IDLE_PCT       = 35;    // chance of a gap / stall per cycle
   localparam int QUIET_FROM     = 300;   // no idling on either side ...
   localparam int QUIET_TO       = 500;   // ... for this range of input transfers
   localparam int HOLD_AT        = 700;   // long receiver hold starts here
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_BYTES   = 1030;  // stream size before the closing frame
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
   localparam int DRAIN_CYCLES   = 20;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_valid   = 1'b0;
   logic                              req_stall;
   logic [wsfd_pkg::BYTE_W-1:0]       req_rx_byte = '0;
   logic                              rsp_valid;
   logic                              rsp_stall   = 1'b0;
   logic                              rsp_item_kind;
   logic                              rsp_fin_flag;
   logic [wsfd_pkg::OPCODE_W-1:0]     rsp_frame_opcode;
   logic                              rsp_mask_flag;
   logic [wsfd_pkg::LEN_W-1:0]        rsp_frame_length;
   logic [wsfd_pkg::BYTE_W-1:0]       rsp_payload_byte;
   logic                              rsp_frame_end;

   // byte stream still to be offered, and results the parser has predicted
   logic [wsfd_pkg::BYTE_W-1:0] stream_bytes[$];
   wsfd_pkg::result_type        expected_results[$];

   int  bytes_sent  = 0;
   int  idle_cycles = 0;
   int  errors      = 0;
   int  hold_left   = 0;
   logic hold_done  = 1'b0;
   logic quiet;

   // shadow copy of the parser state
   wsfd_pkg::phase_type          phase      = wsfd_pkg::PH_BYTE1;
   logic [wsfd_pkg::BYTE_W-1:0]  hdr_byte0  = '0;
   logic                         masked     = 1'b0;
   logic [3:0]                   len_left   = '0;
   logic [wsfd_pkg::LEN_W-1:0]   len_acc    = '0;
   logic [wsfd_pkg::KEY_W-1:0]   mask_key   = '0;
   logic [2:0]                   key_left   = '0;
   logic [wsfd_pkg::LEN_W-1:0]   body_left  = '0;
   logic [1:0]                   key_index  = '0;

   websocket_frame_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_fin_flag     (rsp_fin_flag),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_mask_flag    (rsp_mask_flag),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

   always #5 clock = ~clock;

   assign quiet = (bytes_sent >= QUIET_FROM) && (bytes_sent < QUIET_TO);

   // ---------------------------------------------------------------------
   // Frame builder: header, optional key, then n_body random body bytes.
   // n_body below the declared length gives a truncated frame.
   // ---------------------------------------------------------------------
   task automatic add_frame(input logic [7:0] b0, input logic mask_bit,
                            input logic [wsfd_pkg::LEN_W-1:0] len,
                            input len_form_type form,
                            input int unsigned n_body);
      int unsigned i;
      stream_bytes.push_back(b0);
      case (form)
         LEN_EXT16: begin
            stream_bytes.push_back({mask_bit, wsfd_pkg::LEN7_EXT16});
            stream_bytes.push_back(len[15:8]);
            stream_bytes.push_back(len[7:0]);
         end
         LEN_EXT64: begin
            stream_bytes.push_back({mask_bit, wsfd_pkg::LEN7_EXT64});
            for (i = 0; i < 8; i++)
               stream_bytes.push_back(len[63 - 8 * i -: 8]);
         end
         default: begin
            stream_bytes.push_back({mask_bit, len[6:0]});
         end
      endcase
      if (mask_bit)
         for (i = 0; i < 4; i++)
            stream_bytes.push_back(8'($urandom));
      for (i = 0; i < n_body; i++)
         stream_bytes.push_back(8'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------
   task automatic push_result(input logic kind, input logic [7:0] pbyte,
                              input logic last);
      wsfd_pkg::result_type r;
      r.item_kind    = kind;
      r.fin_flag     = hdr_byte0[7];
      r.frame_opcode = hdr_byte0[3:0];
      r.mask_flag    = masked;
      r.frame_length = len_acc;
      r.payload_byte = pbyte;
      r.frame_end    = last;
      expected_results.push_back(r);
   endtask

   task automatic header_complete();
      logic empty_frame;
      empty_frame = (len_acc == '0);
      body_left   = len_acc;
      key_index   = '0;
      phase       = empty_frame ? wsfd_pkg::PH_BYTE1 : wsfd_pkg::PH_PAYLOAD;
      push_result(wsfd_pkg::ITEM_HEADER, 8'h00, empty_frame);
   endtask

   task automatic length_complete();
      mask_key = '0;
      if (masked) begin
         key_left = wsfd_pkg::KEY_BYTES;
         phase    = wsfd_pkg::PH_KEY;
      end else begin
         header_complete();
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [7:0] key_byte;
      logic       last;
      case (phase)
         wsfd_pkg::PH_BYTE2: begin
            masked  = b[7];
            len_acc = '0;
            if (b[6:0] == wsfd_pkg::LEN7_EXT16) begin
               len_left = wsfd_pkg::EXT16_BYTES;
               phase    = wsfd_pkg::PH_EXTLEN;
            end else if (b[6:0] == wsfd_pkg::LEN7_EXT64) begin
               len_left = wsfd_pkg::EXT64_BYTES;
               phase    = wsfd_pkg::PH_EXTLEN;
            end else begin
               len_acc = wsfd_pkg::LEN_W'(b[6:0]);
               length_complete();
            end
         end
         wsfd_pkg::PH_EXTLEN: begin
            len_acc = {len_acc[wsfd_pkg::LEN_W-9:0], b};   // big-endian
            if (len_left != 0)
               len_left = len_left - 4'd1;
            if (len_left == 0)
               length_complete();
         end
         wsfd_pkg::PH_KEY: begin
            mask_key = {mask_key[wsfd_pkg::KEY_W-9:0], b};
            if (key_left != 0)
               key_left = key_left - 3'd1;
            if (key_left == 0)
               header_complete();
         end
         wsfd_pkg::PH_PAYLOAD: begin
            key_byte  = mask_key[8 * (3 - key_index) +: 8];
            key_index = key_index + 2'd1;
            if (body_left != 0)
               body_left = body_left - 1;
            last = (body_left == 0);
            if (last)
               phase = wsfd_pkg::PH_BYTE1;
            push_result(wsfd_pkg::ITEM_PAYLOAD, b ^ key_byte, last);
         end
         default: begin
            hdr_byte0 = b;
            phase     = wsfd_pkg::PH_BYTE2;
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Request driver: a new byte is offered only once the previous one has
   // gone through, so a stalled byte never changes.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (stream_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid   <= 1'b1;
            req_rx_byte <= stream_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response stall: random, except for the quiet window and one long
   // hold while a result is waiting, so the input side backs up.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && bytes_sent >= HOLD_AT && rsp_valid) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts from each request transfer first, then checks the
   // response transfer of the same edge, so ordering within the step
   // does not matter.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      wsfd_pkg::result_type got;
      wsfd_pkg::result_type want;
      logic                 req_xfer;
      logic                 rsp_xfer;
      if (!reset) begin
         req_xfer = req_valid && !req_stall;
         rsp_xfer = rsp_valid && !rsp_stall;
         if (req_xfer) begin
            deframe_byte(req_rx_byte);
            bytes_sent <= bytes_sent + 1;
         end
         idle_cycles <= (req_xfer || rsp_xfer) ? 0 : idle_cycles + 1;
         if (rsp_xfer) begin
            got.item_kind    = rsp_item_kind;
            got.fin_flag     = rsp_fin_flag;
            got.frame_opcode = rsp_frame_opcode;
            got.mask_flag    = rsp_mask_flag;
            got.frame_length = rsp_frame_length;
            got.payload_byte = rsp_payload_byte;
            got.frame_end    = rsp_frame_end;
            if (expected_results.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10)
                  $display("%t: unexpected result kind=%0d byte=%h end=%0d",
                           $realtime, got.item_kind, got.payload_byte, got.frame_end);
            end else begin
               want = expected_results.pop_front();
               if (got.item_kind    !== want.item_kind    ||
                   got.fin_flag     !== want.fin_flag     ||
                   got.frame_opcode !== want.frame_opcode ||
                   got.mask_flag    !== want.mask_flag    ||
                   got.frame_length !== want.frame_length ||
                   got.payload_byte !== want.payload_byte ||
                   got.frame_end    !== want.frame_end) begin
                  errors = errors + 1;
                  if (errors <= 10) begin
                     $display({"%t: mismatch exp kind=%0d fin=%0d op=%h mask=%0d",
                               " len=%h byte=%h end=%0d"},
                              $realtime, want.item_kind, want.fin_flag, want.frame_opcode,
                              want.mask_flag, want.frame_length, want.payload_byte,
                              want.frame_end);
                     $display({"%t:          got kind=%0d fin=%0d op=%h mask=%0d",
                               " len=%h byte=%h end=%0d"},
                              $realtime, got.item_kind, got.fin_flag, got.frame_opcode,
                              got.mask_flag, got.frame_length, got.payload_byte,
                              got.frame_end);
                  end
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      int           pick;
      int unsigned  frame_len;
      int unsigned  body;
      len_form_type form;

      // directed frames
      add_frame(8'h89, 1'b0, 64'd0, LEN_SHORT, 0);  // empty ping, ends on its header
      add_frame(8'h82, 1'b1, 64'd5, LEN_SHORT, 5);  // masked, key index wraps
      add_frame(8'h73, 1'b0, 64'd1, LEN_EXT16, 1);  // RSV bits set, reserved opcode,
                                                    // non-minimal 16-bit length
      add_frame(8'h0F, 1'b0, 64'd0, LEN_EXT64, 0);  // empty via 64-bit length

      // random frames, mostly short, now and then cut short
      while (stream_bytes.size() < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         form = LEN_SHORT;
         if (pick < 72) begin
            frame_len = $urandom_range(0, 12);
         end else if (pick < 80) begin
            frame_len = $urandom_range(0, 125);
         end else if (pick < 90) begin
            form      = LEN_EXT16;
            frame_len = $urandom_range(0, 160);
         end else begin
            form      = LEN_EXT64;
            frame_len = $urandom_range(0, 20);
         end
         body = frame_len;
         if (frame_len > 3 && $urandom_range(0, 99) < 3)
            body = frame_len - $urandom_range(1, 3);
         add_frame(8'($urandom), 1'($urandom), wsfd_pkg::LEN_W'(frame_len), form, body);
      end

      // closing frame: 64-bit length with every bit set, never completes
      add_frame(8'h81, 1'b1, {wsfd_pkg::LEN_W{1'b1}}, LEN_EXT64, 20);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sample on the falling edge, clear of the rising-edge updates
      while (!(stream_bytes.size() == 0 && !req_valid && expected_results.size() == 0)
             && idle_cycles < WATCHDOG_LIMIT)
         @(negedge clock);

      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         if (expected_results.size() != 0)
            errors = errors + 1;
         if (errors == 0)
            $display("All tests passed");
         else
            $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/wsfd_pkg.sv
sv/wsfd_parser.sv
sv/wsfd_out_reg.sv
sv/websocket_frame_deframer_top.sv
sv/wsfd_checker.sv
tb/websocket_frame_deframer_top_tb.sv
